FILE: rtl/core/hsu_pkg.sv
// Shared types and opcodes for the Hopfield spin update engine.
// No dependencies; used by every module under rtl/core except hsu_ram.
package hsu_pkg;

  localparam logic [2:0] OP_WRITE_WEIGHT = 3'd0;
  localparam logic [2:0] OP_WRITE_SPIN   = 3'd1;
  localparam logic [2:0] OP_READ_SPIN    = 3'd2;
  localparam logic [2:0] OP_SYNC_UPDATE  = 3'd3;
  localparam logic [2:0] OP_ASYNC_UPDATE = 3'd4;

  localparam logic [6:0] FLIP_MAX = 7'd127;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] weight_value;
    logic               spin_value;
  } request_t;

  typedef struct packed {
    logic [5:0] neuron_index;
    logic       neuron_spin;
    logic [6:0] flip_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic init_wr;
    logic wr_weight;
    logic wr_spin;
    logic acc_issue;
    logic old_rd;
    logic sign_spin_wr;
    logic sign_next_wr;
    logic copy_issue;
    logic row_rd;
    logic report;
    logic i_clr;
    logic i_set_row;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic acc_clr;
    logic flips_clr;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       row_ok;
    logic       col_ok;
    logic       i_last;
    logic       j_last;
  } sts_t;

endpackage

FILE: rtl/core/hsu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hsu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/hsu_datapath.sv
// Datapath: weight, spin and scratch RAMs, counters, field accumulator, flip count.
// Depends on hsu_pkg and hsu_ram; driven by hsu_ctrl commands.
module hsu_datapath #(
  parameter int NEURONS     = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  hsu_pkg::request_t request,
  input  hsu_pkg::cmd_t     cmd,
  output hsu_pkg::sts_t     sts,
  output hsu_pkg::result_t  result
);

  localparam int IB       = $clog2(NEURONS);
  localparam int WA       = 2 * IB;
  localparam int WDEPTH   = 1 << WA;
  localparam int ACC_BITS = WEIGHT_BITS + IB + 1;
  localparam logic [IB-1:0] LAST = IB'(NEURONS - 1);

  hsu_pkg::request_t req_r;
  logic [IB-1:0] i_cnt;
  logic [IB-1:0] j_cnt;
  logic [IB-1:0] j_d;
  logic          acc_vld;
  logic          copy_vld;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] acc_next;
  logic signed [ACC_BITS-1:0] wx;
  logic [6:0]    flips;
  logic          sign;
  logic          row_ok;
  logic          col_ok;
  logic [IB-1:0] row_idx;
  logic [IB-1:0] col_idx;

  logic [WEIGHT_BITS-1:0] w_wdata;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [IB-1:0] spin_raddr;
  logic [IB-1:0] spin_waddr;
  logic          spin_wdata;
  logic          spin_we;
  logic          spin_q;
  logic          next_q;

  assign row_idx = IB'(req_r.row_index);
  assign col_idx = IB'(req_r.col_index);
  assign row_ok  = 32'(req_r.row_index) < NEURONS;
  assign col_ok  = 32'(req_r.col_index) < NEURONS;
  assign w_wdata = WEIGHT_BITS'(req_r.weight_value);

  hsu_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WDEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (cmd.wr_weight),
    .waddr ({row_idx, col_idx}),
    .wdata (w_wdata),
    .raddr ({i_cnt, j_cnt}),
    .rdata (w_q)
  );

  hsu_ram #(.WIDTH(1), .DEPTH(NEURONS)) u_spin_ram (
    .clk   (clk),
    .we    (spin_we),
    .waddr (spin_waddr),
    .wdata (spin_wdata),
    .raddr (spin_raddr),
    .rdata (spin_q)
  );

  hsu_ram #(.WIDTH(1), .DEPTH(NEURONS)) u_next_ram (
    .clk   (clk),
    .we    (cmd.sign_next_wr),
    .waddr (i_cnt),
    .wdata (sign),
    .raddr (j_cnt),
    .rdata (next_q)
  );

  always_comb begin
    priority if (cmd.old_rd) begin
      spin_raddr = i_cnt;
    end else if (cmd.row_rd) begin
      spin_raddr = row_idx;
    end else begin
      spin_raddr = j_cnt;
    end
  end

  always_comb begin
    spin_we    = 1'b1;
    spin_waddr = j_d;
    spin_wdata = next_q;
    priority if (cmd.init_wr) begin
      spin_waddr = j_cnt;
      spin_wdata = 1'b1;
    end else if (cmd.wr_spin) begin
      spin_waddr = row_idx;
      spin_wdata = req_r.spin_value;
    end else if (cmd.sign_spin_wr) begin
      spin_waddr = i_cnt;
      spin_wdata = sign;
    end else begin
      spin_we = copy_vld;
    end
  end

  assign wx       = ACC_BITS'($signed(w_q));
  assign acc_next = spin_q ? acc + wx : acc - wx;
  assign sign     = !acc[ACC_BITS-1] && (acc != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= request;
    end
    j_d <= j_cnt;
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (acc_vld) begin
      acc <= acc_next;
    end
    if (cmd.flips_clr) begin
      flips <= '0;
    end else if (cmd.sign_spin_wr) begin
      flips <= {6'd0, sign != spin_q};
    end else if (copy_vld && (next_q != spin_q) && (flips != hsu_pkg::FLIP_MAX)) begin
      flips <= flips + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt    <= '0;
      j_cnt    <= '0;
      acc_vld  <= 1'b0;
      copy_vld <= 1'b0;
    end else begin
      acc_vld  <= cmd.acc_issue;
      copy_vld <= cmd.copy_issue;
      priority if (cmd.i_clr) begin
        i_cnt <= '0;
      end else if (cmd.i_set_row) begin
        i_cnt <= row_idx;
      end else if (cmd.i_inc) begin
        i_cnt <= i_cnt + IB'(1);
      end
      priority if (cmd.j_clr) begin
        j_cnt <= '0;
      end else if (cmd.j_inc) begin
        j_cnt <= j_cnt + IB'(1);
      end
    end
  end

  assign sts.opcode = req_r.opcode;
  assign sts.row_ok = row_ok;
  assign sts.col_ok = col_ok;
  assign sts.i_last = i_cnt == LAST;
  assign sts.j_last = j_cnt == LAST;

  assign result.neuron_index = req_r.row_index;
  assign result.neuron_spin  = row_ok & spin_q;
  assign result.flip_count   = flips;

endmodule

FILE: rtl/core/hsu_ctrl.sv
// Controller state machine: sequences spin-store clear, writes, field sums and copy.
// Depends on hsu_pkg; drives hsu_datapath through cmd_t, reads sts_t.
module hsu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  hsu_pkg::sts_t  sts,
  output hsu_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [9:0] {
    ST_INIT   = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_EXEC   = 10'b00_0000_0100,
    ST_ACC    = 10'b00_0000_1000,
    ST_DRAIN  = 10'b00_0001_0000,
    ST_SIGN   = 10'b00_0010_0000,
    ST_COPY   = 10'b00_0100_0000,
    ST_CDRAIN = 10'b00_1000_0000,
    ST_READ   = 10'b01_0000_0000,
    ST_REPORT = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.j_last) begin
          cmd.j_clr  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        cmd.acc_clr   = 1'b1;
        cmd.flips_clr = 1'b1;
        cmd.j_clr     = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_READ;
        unique case (sts.opcode)
          hsu_pkg::OP_WRITE_WEIGHT: cmd.wr_weight = sts.row_ok & sts.col_ok;
          hsu_pkg::OP_WRITE_SPIN:   cmd.wr_spin = sts.row_ok;
          hsu_pkg::OP_SYNC_UPDATE: begin
            cmd.i_clr  = 1'b1;
            state_next = ST_ACC;
          end
          hsu_pkg::OP_ASYNC_UPDATE: begin
            if (sts.row_ok) begin
              cmd.i_set_row = 1'b1;
              state_next    = ST_ACC;
            end
          end
          default: ;
        endcase
      end
      ST_ACC: begin
        cmd.acc_issue = 1'b1;
        if (sts.j_last) begin
          cmd.j_clr  = 1'b1;
          state_next = ST_DRAIN;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd.old_rd = 1'b1;
        state_next = ST_SIGN;
      end
      ST_SIGN: begin
        cmd.acc_clr = 1'b1;
        if (sts.opcode == hsu_pkg::OP_SYNC_UPDATE) begin
          cmd.sign_next_wr = 1'b1;
          if (sts.i_last) begin
            state_next = ST_COPY;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = ST_ACC;
          end
        end else begin
          cmd.sign_spin_wr = 1'b1;
          state_next       = ST_READ;
        end
      end
      ST_COPY: begin
        cmd.copy_issue = 1'b1;
        if (sts.j_last) begin
          cmd.j_clr  = 1'b1;
          state_next = ST_CDRAIN;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      ST_CDRAIN: state_next = ST_READ;
      ST_READ: begin
        cmd.row_rd = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

FILE: rtl/core/hopfield_spin_update_top.sv
// Top level of the Hopfield spin update engine.
// Depends on hsu_pkg, hsu_ctrl, hsu_datapath and hsu_ram.
//
// Usage:
//   Command channel: drive request and raise start; the word is taken at a
//   rising edge where start is high and busy is low. One command at a time.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver must take it then, it cannot stall the block.
//   Work per command, N = NEURONS:
//     weight write, spin write, spin read, unused opcodes: any write, then
//       a read of the addressed spin for the result word
//     asynchronous update of one neuron: one field sum over N weights (one
//       weight and one spin per cycle from the weight and spin RAM read ports)
//     synchronous update: N field sums of N weights each, then a copy pass
//       over the spin store
//   A new command is taken only once the block is idle after its result.
//   Reset: rst clears control, then a clearing pass writes +1 into every
//   spin; busy stays high during that pass. Weights are undefined until
//   written.
module hopfield_spin_update_top #(
  parameter int NEURONS     = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hsu_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output hsu_pkg::result_t  result
);

  hsu_pkg::cmd_t cmd;
  hsu_pkg::sts_t sts;

  hsu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  hsu_datapath #(.NEURONS(NEURONS), .WEIGHT_BITS(WEIGHT_BITS)) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

  assign done = cmd.report;

endmodule

FILE: rtl/core/hsu_checker.sv
// Port-level checks for the Hopfield spin update engine, bound to the top level.
// Depends on hsu_pkg and hopfield_spin_update_top.
module hsu_port_checks (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input hsu_pkg::result_t result
);

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result word outside a busy period");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result word repeated");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("block still busy after its result word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done)) else $error("accepted word not processed");

  a_flip_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.flip_count != 7'd0 || !$isunknown(result.flip_count)))
    else $error("flip count unknown");

endmodule

bind hopfield_spin_update_top hsu_port_checks u_hsu_port_checks (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
